@@ hdl/pcft_pkg.sv @@
`default_nettype none
package pcft_pkg;

	localparam int BYTE_W     = 8;
	localparam int POS_W      = 4;
	localparam int TICK_W     = 8;
	localparam int BIT_CNT_W  = 4;
	localparam int BYTE_CNT_W = 5;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_LOAD  = 2'd1,
		MODE_START = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		REG_LEAD      = 2'd0,
		REG_SYNC_LOW  = 2'd1,
		REG_SYNC_HIGH = 2'd2,
		REG_BIT_PHASE = 2'd3
	} reg_idx_t;

	localparam logic [TICK_W-1:0] LEAD_TICKS_RST      = 8'd4;
	localparam logic [TICK_W-1:0] SYNC_LOW_TICKS_RST  = 8'd20;
	localparam logic [TICK_W-1:0] SYNC_HIGH_TICKS_RST = 8'd15;
	localparam logic [TICK_W-1:0] BIT_PHASE_TICKS_RST = 8'd5;

	typedef struct packed {
		mode_t             mode;
		logic [POS_W-1:0]  byte_index;
		logic [BYTE_W-1:0] byte_value;
	} item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
	} result_t;

	typedef struct packed {
		reg_idx_t          index;
		logic [BYTE_W-1:0] value;
	} cfg_wr_t;

	typedef struct packed {
		logic [TICK_W-1:0] lead_ticks;
		logic [TICK_W-1:0] sync_low_ticks;
		logic [TICK_W-1:0] sync_high_ticks;
		logic [TICK_W-1:0] bit_phase_ticks;
	} cfg_regs_t;

endpackage
`default_nettype wire

@@ hdl/pcft_stream_if.sv @@
`default_nettype none
interface pcft_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/pulse_coded_frame_transmitter.sv @@
`default_nettype none
// An item is held in the input register, then its result in the result register.
// One item per cycle unless the sink stalls; the sequencer state is updated in a single pass.
// Result register holds while the sink stalls; the input register backs up behind it.
// Reset clears the sequencer, loads the phase length registers with their defaults and
// drives the line idle high. Frame bytes are not cleared.
module pulse_coded_frame_transmitter #(
	parameter int FRAME_BYTES = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	pcft_stream_if.sink   item,
	pcft_stream_if.source result,
	pcft_stream_if.sink   cfg
);
	import pcft_pkg::*;

	localparam int IDX_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

	item_t             item_s1;
	logic              valid_s1;
	logic              advance;
	result_t           res_s2;
	result_t           res_n;
	logic              res_valid_s2;
	cfg_regs_t         regs;
	logic              wr_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [BYTE_W-1:0] rd_data;

	assign advance    = valid_s1 && (!res_valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	pcft_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	assign wr_en = advance && (item_s1.mode == MODE_LOAD)
		&& ({1'b0, item_s1.byte_index} < (POS_W+1)'(FRAME_BYTES));

	pcft_frame_store #(
		.FRAME_BYTES (FRAME_BYTES),
		.IDX_W       (IDX_W)
	) u_frame_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (item_s1.byte_index[IDX_W-1:0]),
		.wr_data (item_s1.byte_value),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pcft_engine #(
		.FRAME_BYTES (FRAME_BYTES),
		.IDX_W       (IDX_W)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.regs    (regs),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.res     (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (result.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_n;
		end
	end

	assign result.valid = res_valid_s2;
	assign result.data  = res_s2;
endmodule
`default_nettype wire

@@ hdl/pcft_cfg_regs.sv @@
`default_nettype none
module pcft_cfg_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	pcft_stream_if.sink       cfg,
	output pcft_pkg::cfg_regs_t regs
);
	import pcft_pkg::*;

	cfg_regs_t regs_q;
	cfg_wr_t   wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.data;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.lead_ticks      <= LEAD_TICKS_RST;
			regs_q.sync_low_ticks  <= SYNC_LOW_TICKS_RST;
			regs_q.sync_high_ticks <= SYNC_HIGH_TICKS_RST;
			regs_q.bit_phase_ticks <= BIT_PHASE_TICKS_RST;
		end else if (cfg.valid) begin
			unique case (wr.index)
				REG_LEAD:      regs_q.lead_ticks      <= wr.value;
				REG_SYNC_LOW:  regs_q.sync_low_ticks  <= wr.value;
				REG_SYNC_HIGH: regs_q.sync_high_ticks <= wr.value;
				REG_BIT_PHASE: regs_q.bit_phase_ticks <= wr.value;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ hdl/pcft_frame_store.sv @@
`default_nettype none
module pcft_frame_store #(
	parameter int FRAME_BYTES = 4,
	parameter int IDX_W       = 2
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [IDX_W-1:0]            wr_addr,
	input  wire logic [pcft_pkg::BYTE_W-1:0] wr_data,
	input  wire logic [IDX_W-1:0]            rd_addr,
	output      logic [pcft_pkg::BYTE_W-1:0] rd_data
);
	import pcft_pkg::*;

	logic [BYTE_W-1:0] store_q [FRAME_BYTES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
	end

	assign rd_data = store_q[rd_addr];
endmodule
`default_nettype wire

@@ hdl/pcft_engine.sv @@
`default_nettype none
module pcft_engine #(
	parameter int FRAME_BYTES = 4,
	parameter int IDX_W       = 2
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step_en,
	input  wire pcft_pkg::item_t             item,
	input  wire pcft_pkg::cfg_regs_t         regs,
	output      logic [IDX_W-1:0]            rd_addr,
	input  wire logic [pcft_pkg::BYTE_W-1:0] rd_data,
	output      pcft_pkg::result_t           res
);
	import pcft_pkg::*;

	typedef enum logic [2:0] {
		STEP_LEAD0     = 3'd0,
		STEP_LEAD1     = 3'd1,
		STEP_LEAD2     = 3'd2,
		STEP_SYNC_LOW  = 3'd3,
		STEP_SYNC_HIGH = 3'd4,
		STEP_DATA      = 3'd5
	} step_t;

	localparam logic [BYTE_CNT_W-1:0] LAST_POS = BYTE_CNT_W'(FRAME_BYTES);

	logic                  sending_q, sending_n;
	logic [TICK_W-1:0]     tick_q, tick_n;
	step_t                 step_q, step_n, step_nx;
	logic [1:0]            bphase_q, bphase_n;
	logic [BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_n;
	logic [BYTE_CNT_W-1:0] byte_cnt_q, byte_cnt_n;
	logic [BYTE_W-1:0]     shift_q, shift_n;
	logic                  pin_q, pin_n;
	logic [BYTE_CNT_W-1:0] fetch_pos;
	logic [TICK_W-1:0]     phase_len;
	logic [TICK_W:0]       elapsed;

	always_comb begin
		priority if (step_q <= STEP_LEAD2) begin
			phase_len = regs.lead_ticks;
		end else if (step_q == STEP_SYNC_LOW) begin
			phase_len = regs.sync_low_ticks;
		end else if (step_q == STEP_SYNC_HIGH) begin
			phase_len = regs.sync_high_ticks;
		end else begin
			phase_len = regs.bit_phase_ticks;
		end
	end

	assign elapsed = {1'b0, tick_q} + (TICK_W+1)'(1);
	assign step_nx = (step_q < STEP_DATA) ? step_t'(step_q + 3'd1) : step_q;
	assign rd_addr = fetch_pos[IDX_W-1:0];

	always_comb begin
		sending_n  = sending_q;
		tick_n     = tick_q;
		step_n     = step_q;
		bphase_n   = bphase_q;
		bit_cnt_n  = bit_cnt_q;
		byte_cnt_n = byte_cnt_q;
		shift_n    = shift_q;
		pin_n      = pin_q;
		fetch_pos  = '0;
		unique case (item.mode)
			MODE_TICK: begin
				if (sending_q) begin
					if (elapsed >= {1'b0, phase_len}) begin
						tick_n = '0;
						step_n = step_nx;
						unique case (step_nx)
							STEP_DATA: begin
								bphase_n = bphase_q + 2'd1;
								if (bphase_n == 2'd1) begin
									pin_n = 1'b0;
								end else if (bphase_n == 2'd2) begin
									if (byte_cnt_q < LAST_POS) begin
										pin_n   = ~shift_q[0];
										shift_n = shift_q >> 1;
									end else begin
										sending_n = 1'b0;
									end
								end else begin
									bphase_n  = 2'd0;
									pin_n     = 1'b1;
									bit_cnt_n = bit_cnt_q + BIT_CNT_W'(1);
								end
								if (bit_cnt_n > BIT_CNT_W'(7)) begin
									bit_cnt_n  = '0;
									byte_cnt_n = byte_cnt_q + BYTE_CNT_W'(1);
									fetch_pos  = byte_cnt_n;
									if (byte_cnt_n < LAST_POS) begin
										shift_n = rd_data;
									end
								end
							end
							STEP_SYNC_HIGH: begin
								pin_n      = 1'b1;
								bit_cnt_n  = '0;
								byte_cnt_n = '0;
								bphase_n   = 2'd0;
								shift_n    = rd_data;
							end
							STEP_SYNC_LOW: pin_n = 1'b0;
							STEP_LEAD2:    pin_n = 1'b1;
							default:       pin_n = 1'b0;
						endcase
					end else begin
						tick_n = elapsed[TICK_W-1:0];
					end
					if (!sending_n) begin
						bphase_n = 2'd0;
						step_n   = STEP_LEAD0;
						pin_n    = 1'b1;
					end
				end
			end
			MODE_START: begin
				if (!sending_q) begin
					sending_n = 1'b1;
					tick_n    = '0;
					step_n    = STEP_LEAD0;
					bphase_n  = 2'd0;
					pin_n     = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sending_q  <= 1'b0;
			tick_q     <= '0;
			step_q     <= STEP_LEAD0;
			bphase_q   <= 2'd0;
			bit_cnt_q  <= '0;
			byte_cnt_q <= '0;
			shift_q    <= '0;
			pin_q      <= 1'b1;
		end else if (step_en) begin
			sending_q  <= sending_n;
			tick_q     <= tick_n;
			step_q     <= step_n;
			bphase_q   <= bphase_n;
			bit_cnt_q  <= bit_cnt_n;
			byte_cnt_q <= byte_cnt_n;
			shift_q    <= shift_n;
			pin_q      <= pin_n;
		end
	end

	assign res.line_level = pin_n;
	assign res.busy_res   = sending_n;
endmodule
`default_nettype wire

@@ verif/pulse_coded_frame_transmitter_tb.sv @@
`default_nettype none
module pulse_coded_frame_transmitter_tb;
	import pcft_pkg::*;

	localparam int FRAME_BYTES = 4;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		item_t   it;
		bit      known;
		result_t res;
	} dir_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always #4 clk = ~clk;

	pcft_stream_if #(.payload_t(item_t))   item_if ();
	pcft_stream_if #(.payload_t(result_t)) result_if ();
	pcft_stream_if #(.payload_t(cfg_wr_t)) cfg_if ();

	pulse_coded_frame_transmitter #(.FRAME_BYTES(FRAME_BYTES)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if),
		.cfg    (cfg_if)
	);

	// transmitter shadow: phase lengths
	logic [TICK_W-1:0] len_lead    = LEAD_TICKS_RST;
	logic [TICK_W-1:0] len_sync_lo = SYNC_LOW_TICKS_RST;
	logic [TICK_W-1:0] len_sync_hi = SYNC_HIGH_TICKS_RST;
	logic [TICK_W-1:0] len_bit     = BIT_PHASE_TICKS_RST;

	// transmitter shadow: sequencer
	logic                  tx_on    = 1'b0;
	logic [TICK_W-1:0]     tick_cnt = '0;
	logic [2:0]            seq_step = '0;
	logic [1:0]            bit_slot = '0;
	logic [BIT_CNT_W-1:0]  bit_cnt  = '0;
	logic [BYTE_CNT_W-1:0] byte_cnt = '0;
	logic [BYTE_W-1:0]     shreg    = '0;
	logic [BYTE_W-1:0]     frame_mem [FRAME_BYTES];
	logic                  pin      = 1'b1;

	result_t  pending_levels [$];
	dir_row_t dir_tab [$];

	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	bit hold_req     = 1'b0;
	int hold_left    = 0;

	int n_items    = 0;
	int n_checked  = 0;
	int n_settings = 0;
	int n_frames   = 0;
	int n_errors   = 0;

	function automatic item_t make_item(logic [1:0] m, logic [POS_W-1:0] idx,
			logic [BYTE_W-1:0] v);
		return item_t'({m, idx, v});
	endfunction

	function automatic int phase_len(logic [2:0] s);
		if (s < 3'd3) return int'(len_lead);
		if (s == 3'd3) return int'(len_sync_lo);
		if (s == 3'd4) return int'(len_sync_hi);
		return int'(len_bit);
	endfunction

	function automatic logic [BYTE_W-1:0] frame_byte(int pos);
		if (pos < FRAME_BYTES) return frame_mem[pos];
		return '0;
	endfunction

	task automatic next_data_phase();
		bit_slot = bit_slot + 2'd1;
		if (bit_slot == 2'd1) begin
			pin = 1'b0;
		end else if (bit_slot == 2'd2) begin
			if (byte_cnt < FRAME_BYTES) begin
				pin   = ~shreg[0];
				shreg = shreg >> 1;
			end else begin
				tx_on = 1'b0;
			end
		end else begin
			bit_slot = '0;
			pin      = 1'b1;
			bit_cnt  = bit_cnt + 1'b1;
		end
		if (bit_cnt > 7) begin
			bit_cnt  = '0;
			byte_cnt = byte_cnt + 1'b1;
			if (byte_cnt < FRAME_BYTES) shreg = frame_byte(int'(byte_cnt));
		end
	endtask

	task automatic tick_line();
		int elapsed;
		if (!tx_on) return;
		elapsed = int'(tick_cnt) + 1;
		if (elapsed >= phase_len(seq_step)) begin
			tick_cnt = '0;
			if (seq_step < 3'd5) seq_step = seq_step + 3'd1;
			case (seq_step)
				3'd5: next_data_phase();
				3'd4: begin
					pin      = 1'b1;
					bit_cnt  = '0;
					byte_cnt = '0;
					bit_slot = '0;
					shreg    = frame_byte(0);
				end
				3'd3: pin = 1'b0;
				3'd2: pin = 1'b1;
				default: pin = 1'b0;
			endcase
		end else begin
			tick_cnt = TICK_W'(elapsed);
		end
		if (!tx_on) begin
			bit_slot = '0;
			seq_step = '0;
			pin      = 1'b1;
		end
	endtask

	task automatic predict_line(item_t it, output result_t r);
		case (it.mode)
			MODE_TICK: tick_line();
			MODE_LOAD: begin
				if (it.byte_index < FRAME_BYTES) frame_mem[it.byte_index] = it.byte_value;
			end
			MODE_START: begin
				if (!tx_on) begin
					tx_on    = 1'b1;
					tick_cnt = '0;
					seq_step = '0;
					bit_slot = '0;
					pin      = 1'b1;
					n_frames++;
				end
			end
			default: ;
		endcase
		r.line_level = pin;
		r.busy_res   = tx_on;
	endtask

	task automatic flag_mismatch(string what);
		$display("MISMATCH @%0t: %s", $time, what);
		n_errors++;
	endtask

	task automatic compare_line(result_t got);
		result_t want;
		if (pending_levels.size() == 0) begin
			flag_mismatch($sformatf("unexpected result level=%b busy=%b",
				got.line_level, got.busy_res));
			return;
		end
		want = pending_levels.pop_front();
		n_checked++;
		if (got.line_level !== want.line_level)
			flag_mismatch($sformatf("result %0d line_level got %b want %b",
				n_checked, got.line_level, want.line_level));
		if (got.busy_res !== want.busy_res)
			flag_mismatch($sformatf("result %0d busy_res got %b want %b",
				n_checked, got.busy_res, want.busy_res));
	endtask

	task automatic send_item(item_t it, bit known = 1'b0, result_t typed = '0);
		result_t r;
		if ($urandom_range(99) < snd_idle_pct) begin
			item_if.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.data  <= it;
		do @(posedge clk); while (!item_if.ready);
		predict_line(it, r);
		pending_levels.push_back(known ? typed : r);
		n_items++;
	endtask

	task automatic await_drain();
		item_if.valid <= 1'b0;
		do @(posedge clk); while (pending_levels.size() != 0);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [BYTE_W-1:0] v);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= '{index: idx, value: v};
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			REG_LEAD:      len_lead    = v;
			REG_SYNC_LOW:  len_sync_lo = v;
			REG_SYNC_HIGH: len_sync_hi = v;
			REG_BIT_PHASE: len_bit     = v;
			default: ;
		endcase
	endtask

	task automatic program_regs(logic [BYTE_W-1:0] lead, logic [BYTE_W-1:0] slo,
			logic [BYTE_W-1:0] shi, logic [BYTE_W-1:0] bitp);
		write_reg(REG_LEAD, lead);
		write_reg(REG_SYNC_LOW, slo);
		write_reg(REG_SYNC_HIGH, shi);
		write_reg(REG_BIT_PHASE, bitp);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	task automatic set_idle(int m);
		case (m)
			0: begin snd_idle_pct = 11; rcv_idle_pct = 60; end
			1: begin snd_idle_pct = 60; rcv_idle_pct = 11; end
			default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
		endcase
	endtask

	task automatic add_row(logic [1:0] m, logic [POS_W-1:0] idx, logic [BYTE_W-1:0] v,
			bit known = 1'b0, logic lvl = 1'b1, logic busy = 1'b0);
		dir_row_t row;
		row.it             = make_item(m, idx, v);
		row.known          = known;
		row.res.line_level = lvl;
		row.res.busy_res   = busy;
		dir_tab.push_back(row);
	endtask

	task automatic send_random();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			send_item(make_item(MODE_TICK, POS_W'($urandom_range(15)),
				BYTE_W'($urandom_range(255))));
		else if (r < 78)
			send_item(make_item(MODE_LOAD, POS_W'($urandom_range(15)),
				BYTE_W'($urandom_range(255))));
		else if (r < 86)
			send_item(make_item(MODE_LOAD, POS_W'($urandom_range(FRAME_BYTES - 1)),
				BYTE_W'($urandom_range(255))));
		else if (r < 94)
			send_item(make_item(MODE_START, POS_W'($urandom_range(15)),
				BYTE_W'($urandom_range(255))));
		else
			send_item(make_item(MODE_UNUSED, POS_W'($urandom_range(15)),
				BYTE_W'($urandom_range(255))));
	endtask

	// fresh frame, random traffic, then ticks until the frame is out
	task automatic run_phase(int n_rand, bit pressure);
		for (int p = 0; p < FRAME_BYTES; p++)
			send_item(make_item(MODE_LOAD, POS_W'(p), BYTE_W'($urandom_range(255))));
		send_item(make_item(MODE_START, '0, '0));
		for (int i = 0; i < n_rand; i++) begin
			if (pressure && i == 20) hold_req = 1'b1;
			if (pressure && i == 40) await_drain();
			send_random();
		end
		while (tx_on) send_item(make_item(MODE_TICK, '0, '0));
		await_drain();
		repeat (4) @(posedge clk);
	endtask

	initial begin
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_if.valid && result_if.ready) compare_line(result_if.data);
			if (hold_req) begin
				hold_left = 300;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	initial begin
		#4800000;
		$display("pulse_coded_frame_transmitter test failed");
		$finish;
	end

	initial begin
		item_if.valid <= 1'b0;
		item_if.data  <= '0;
		cfg_if.valid  <= 1'b0;
		cfg_if.data   <= '0;
		for (int p = 0; p < FRAME_BYTES; p++) frame_mem[p] = '0;

		// idle behavior, loads, start, busy start, busy load, first lead edges
		add_row(MODE_TICK,   4'd0,  8'h00, 1'b1, 1'b1, 1'b0);
		add_row(MODE_UNUSED, 4'd15, 8'hff, 1'b1, 1'b1, 1'b0);
		add_row(MODE_LOAD,   4'd0,  8'h00, 1'b1, 1'b1, 1'b0);
		add_row(MODE_LOAD,   4'd1,  8'hff, 1'b1, 1'b1, 1'b0);
		add_row(MODE_LOAD,   4'd2,  8'ha5, 1'b1, 1'b1, 1'b0);
		add_row(MODE_LOAD,   4'd3,  8'h5a, 1'b1, 1'b1, 1'b0);
		add_row(MODE_LOAD,   4'd4,  8'h77, 1'b1, 1'b1, 1'b0);
		add_row(MODE_LOAD,   4'd15, 8'hff, 1'b1, 1'b1, 1'b0);
		add_row(MODE_UNUSED, 4'd0,  8'h00, 1'b1, 1'b1, 1'b0);
		add_row(MODE_START,  4'd0,  8'h00, 1'b1, 1'b1, 1'b1);
		add_row(MODE_START,  4'd9,  8'h3c, 1'b1, 1'b1, 1'b1);
		add_row(MODE_TICK,   4'd0,  8'h00, 1'b1, 1'b1, 1'b1);
		add_row(MODE_TICK,   4'd0,  8'h00, 1'b1, 1'b1, 1'b1);
		add_row(MODE_TICK,   4'd0,  8'h00, 1'b1, 1'b1, 1'b1);
		add_row(MODE_TICK,   4'd0,  8'h00, 1'b1, 1'b0, 1'b1);
		add_row(MODE_LOAD,   4'd2,  8'h3c, 1'b1, 1'b0, 1'b1);
		add_row(MODE_UNUSED, 4'd7,  8'h81, 1'b1, 1'b0, 1'b1);
		add_row(MODE_TICK,   4'd0,  8'h00);
		add_row(MODE_TICK,   4'd0,  8'h00);
		add_row(MODE_TICK,   4'd0,  8'h00);
		add_row(MODE_TICK,   4'd0,  8'h00);
		add_row(MODE_LOAD,   4'd8,  8'h01);
		add_row(MODE_TICK,   4'd0,  8'h00);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idle(0);
		foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].known, dir_tab[i].res);
		// shorten the phases while the frame is running
		await_drain();
		program_regs(8'd1, 8'd1, 8'd1, 8'd1);
		while (tx_on) send_item(make_item(MODE_TICK, '0, '0));
		await_drain();
		repeat (4) @(posedge clk);

		run_phase(70, 1'b1);

		set_idle(1);
		// zero length acts as a single tick
		program_regs(8'd0, 8'd0, 8'd0, 8'd0);
		run_phase(70, 1'b0);

		set_idle(2);
		// longest lengths, then lowered in the middle of the first lead phase
		program_regs(8'd255, 8'd255, 8'd255, 8'd1);
		for (int p = 0; p < FRAME_BYTES; p++)
			send_item(make_item(MODE_LOAD, POS_W'(p), BYTE_W'($urandom_range(255))));
		send_item(make_item(MODE_START, '0, '0));
		repeat (40) send_item(make_item(MODE_TICK, '0, '0));
		await_drain();
		program_regs(BYTE_W'($urandom_range(1, 3)), BYTE_W'($urandom_range(1, 3)),
			BYTE_W'($urandom_range(1, 3)), 8'd1);
		while (tx_on) send_item(make_item(MODE_TICK, '0, '0));
		await_drain();
		repeat (10) @(posedge clk);

		$display("coverage: %0d items, %0d results checked, %0d frames sent, %0d register sets",
			n_items, n_checked, n_frames, n_settings);
		$display("errors: %0d mismatches", n_errors);
		if (n_errors == 0) begin
			$display("pulse_coded_frame_transmitter test passed");
		end else begin
			$display("pulse_coded_frame_transmitter test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
